// File: src/pvgb_pkg.sv
// Package for the point velocity grid binner: item types, opcodes and constants.
// No dependencies; every other source file imports it.
package pvgb_pkg;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [19:0] x_pos;
        logic signed [19:0] y_pos;
        logic signed [15:0] velocity;
        logic [9:0]         row_select;
        logic [9:0]         col_select;
    } t_in;

    typedef struct packed {
        logic               in_grid;
        logic [9:0]         cell_row;
        logic [9:0]         cell_col;
        logic [23:0]        hit_count;
        logic signed [15:0] mean_velocity;
    } t_out;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // divider operand selects
    localparam logic [2:0] DS_ROWS = 3'd0;
    localparam logic [2:0] DS_COLS = 3'd1;
    localparam logic [2:0] DS_X    = 3'd2;
    localparam logic [2:0] DS_Y    = 3'd3;
    localparam logic [2:0] DS_MEAN = 3'd4;

    localparam logic [19:0] X_SPAN  = 20'd128000;
    localparam logic [19:0] Y_SPAN  = 20'd76800;
    localparam logic [20:0] Y_MAX   = 21'd38400;
    localparam logic [23:0] HIT_MAX = 24'hFFFFFF;

    localparam logic [5:0] ITERS_COORD = 6'd20;
    localparam logic [5:0] ITERS_MEAN  = 6'd40;

    localparam logic [2:0] REG_ADDR_CELL_SIZE = 3'd0;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [2:0] div_sel;
        logic       check;
        logic       addr;
        logic       rd;
        logic       upd;
        logic       clr_rst;
        logic       clr_wr;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       div_done;
        logic       ok;
        logic       cnt_zero;
        logic       clr_last;
    } t_stat;

endpackage

// File: src/point_velocity_grid_binner_core.sv
// Top level of the point velocity grid binner: APB register and channel wiring.
// Depends on pvgb_pkg, pvgb_ctrl, pvgb_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes one item: add a point,
//   read a cell, or clear the grid. Each item yields exactly one result item
//   on the output channel (o_out_valid / i_out_ready / o_out).
//   One item is worked at a time. A shared one-bit-per-cycle divider computes
//   grid rows and columns from cell_size, for an add the row and column of
//   the point, then the mean when the cell holds points. A clear sweeps the
//   whole store. The next item can be taken in the cycle after the result is
//   loaded. After reset the same clearing pass runs with o_in_ready low;
//   APB writes are taken anyway.
//   A finished result waits in the output register while the receiver stalls;
//   the next item is accepted meanwhile, but its result waits until the
//   previous one is taken.
//   cell_size sits at APB byte address 0; write it only while idle.
module point_velocity_grid_binner_core #(
    parameter int GRID_ROWS = 1024,
    parameter int GRID_COLS = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pvgb_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pvgb_pkg::t_out o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import pvgb_pkg::*;

    logic [15:0] r_cell_size;
    t_cmd        w_cmd;
    t_stat       w_stat;

    // cell_size register; writes to other addresses are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= 16'd128;
        end else if (psel && penable && pwrite && paddr == REG_ADDR_CELL_SIZE) begin
            r_cell_size <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ADDR_CELL_SIZE) ? {16'd0, r_cell_size} : 32'd0;

    pvgb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in.opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    pvgb_dp #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in        (i_in),
        .i_cell_size (r_cell_size),
        .o_out       (o_out)
    );
endmodule

// File: src/pvgb_div.sv
// Restoring divider, one quotient bit per cycle, up to 40-bit dividend.
// Depends on pvgb_pkg.
module pvgb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_dvd,
    input  logic [23:0] i_dvs,
    input  logic [5:0]  i_iters,
    output logic [39:0] o_quo,
    output logic        o_done
);
    import pvgb_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [23:0] r_rem;
    logic [23:0] r_dvs;
    logic [39:0] r_q;
    logic [24:0] w_t;
    logic        w_ge;
    logic [24:0] w_diff;

    assign w_t    = {r_rem, r_q[39]};
    assign w_ge   = w_t >= {1'b0, r_dvs};
    assign w_diff = w_t - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_iters;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 6'd1;
            r_done <= (r_cnt == 6'd1);
            r_busy <= (r_cnt != 6'd1);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_q   <= {r_q[38:0], w_ge};
            r_rem <= w_ge ? w_diff[23:0] : w_t[23:0];
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;
endmodule

// File: src/pvgb_dp.sv
// Datapath: item registers, shared divider, cell store and result register.
// Depends on pvgb_pkg and pvgb_div.
module pvgb_dp #(
    parameter int GRID_ROWS = 1024,
    parameter int GRID_COLS = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pvgb_pkg::t_cmd  i_cmd,
    output pvgb_pkg::t_stat o_stat,
    input  pvgb_pkg::t_in   i_in,
    input  logic [15:0]     i_cell_size,
    output pvgb_pkg::t_out  o_out
);
    import pvgb_pkg::*;

    localparam int N  = GRID_ROWS * GRID_COLS;
    localparam int AW = $clog2(N);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);

    t_in                r_in;
    t_out               r_out;
    logic [2:0]         r_dst;
    logic [17:0]        r_frows;
    logic [17:0]        r_fcols;
    logic [19:0]        r_qx;
    logic [19:0]        r_qy;
    logic [15:0]        r_mean;
    logic               r_ok;
    logic [RW-1:0]      r_arow;
    logic [CW-1:0]      r_acol;
    logic [9:0]         r_orow;
    logic [9:0]         r_ocol;
    logic [AW-1:0]      r_addr;
    logic [63:0]        r_rdata;
    logic [23:0]        r_cnt;
    logic signed [39:0] r_sum;
    logic [AW-1:0]      r_clr_addr;
    logic [63:0]        mem [N];

    logic [15:0]        w_edge;
    logic [19:0]        w_em1;
    logic [20:0]        w_xn;
    logic signed [20:0] w_ya;
    logic [20:0]        w_yan;
    logic [39:0]        w_sabs;
    logic [19:0]        w_dvd20;
    logic [39:0]        w_dvd;
    logic [23:0]        w_dvs;
    logic [5:0]         w_iters;
    logic [39:0]        w_quo;
    logic               w_done;
    logic signed [22:0] w_r;
    logic signed [22:0] w_c;
    logic [17:0]        w_urows;
    logic [17:0]        w_ucols;
    logic               w_ok_add;
    logic               w_ok_rd;
    logic [23:0]        w_cnt;
    logic signed [39:0] w_sum;
    logic               w_inc;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [63:0]        w_wdata;

    assign w_edge = (i_cell_size == 16'd0) ? 16'd1 : i_cell_size;
    assign w_em1  = {4'd0, w_edge} - 20'd1;
    assign w_xn   = -{r_in.x_pos[19], r_in.x_pos};
    assign w_ya   = $signed(Y_MAX) - $signed({r_in.y_pos[19], r_in.y_pos});
    assign w_yan  = -w_ya;
    assign w_sabs = r_sum[39] ? -r_sum : r_sum;

    // floor division of a negative value: divide (|a| + e - 1) and negate
    always_comb begin
        case (i_cmd.div_sel)
            DS_ROWS: w_dvd20 = X_SPAN + w_em1;
            DS_COLS: w_dvd20 = Y_SPAN + w_em1;
            DS_X:    w_dvd20 = r_in.x_pos[19] ? w_xn[19:0] + w_em1 : r_in.x_pos;
            DS_Y:    w_dvd20 = w_ya[20] ? w_yan[19:0] + w_em1 : w_ya[19:0];
            default: w_dvd20 = '0;
        endcase
    end

    assign w_dvd   = (i_cmd.div_sel == DS_MEAN) ? w_sabs : {w_dvd20, 20'd0};
    assign w_dvs   = (i_cmd.div_sel == DS_MEAN) ? r_cnt : {8'd0, w_edge};
    assign w_iters = (i_cmd.div_sel == DS_MEAN) ? ITERS_MEAN : ITERS_COORD;

    pvgb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .i_iters (w_iters),
        .o_quo   (w_quo),
        .o_done  (w_done)
    );

    // row = rows - 1 - floor(x / e), col = floor((Y_MAX - y) / e)
    assign w_r = $signed({5'd0, r_frows}) - 23'sd1
               + (r_in.x_pos[19] ? $signed({3'd0, r_qx}) : -$signed({3'd0, r_qx}));
    assign w_c = w_ya[20] ? -$signed({3'd0, r_qy}) : $signed({3'd0, r_qy});
    assign w_urows = (r_frows < 18'(GRID_ROWS)) ? r_frows : 18'(GRID_ROWS);
    assign w_ucols = (r_fcols < 18'(GRID_COLS)) ? r_fcols : 18'(GRID_COLS);
    assign w_ok_add = !w_r[22] && (w_r[21:0] < {4'd0, w_urows})
                   && !w_c[22] && (w_c[21:0] < {4'd0, w_ucols});
    assign w_ok_rd  = ({8'd0, r_in.row_select} < w_urows)
                   && ({8'd0, r_in.col_select} < w_ucols);

    assign w_cnt = r_rdata[23:0];
    assign w_sum = $signed(r_rdata[63:24]);
    assign w_inc = (r_in.opcode == OP_ADD) && r_ok && (w_cnt != HIT_MAX);

    assign w_we    = i_cmd.clr_wr || (i_cmd.upd && w_inc);
    assign w_waddr = i_cmd.clr_wr ? r_clr_addr : r_addr;
    assign w_wdata = i_cmd.clr_wr ? 64'd0
                   : {w_sum + 40'(r_in.velocity), w_cnt + 24'd1};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_rst) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
        if (i_cmd.div_start) begin
            r_dst <= i_cmd.div_sel;
        end
        if (w_done) begin
            case (r_dst)
                DS_ROWS: r_frows <= w_quo[17:0];
                DS_COLS: r_fcols <= w_quo[17:0];
                DS_X:    r_qx    <= w_quo[19:0];
                DS_Y:    r_qy    <= w_quo[19:0];
                DS_MEAN: r_mean  <= r_sum[39] ? -w_quo[15:0] : w_quo[15:0];
                default: r_mean  <= r_mean;
            endcase
        end
        if (i_cmd.check) begin
            if (r_in.opcode == OP_ADD) begin
                r_ok   <= w_ok_add;
                r_arow <= RW'(w_r[21:0]);
                r_acol <= CW'(w_c[21:0]);
                r_orow <= w_ok_add ? w_r[9:0] : 10'd0;
                r_ocol <= w_ok_add ? w_c[9:0] : 10'd0;
            end else begin
                r_ok   <= w_ok_rd;
                r_arow <= RW'(r_in.row_select);
                r_acol <= CW'(r_in.col_select);
                r_orow <= r_in.row_select;
                r_ocol <= r_in.col_select;
            end
        end
        if (i_cmd.addr) begin
            r_addr <= AW'(r_arow) * AW'(GRID_COLS) + AW'(r_acol);
        end
        if (i_cmd.upd) begin
            r_cnt <= r_ok ? (w_inc ? w_cnt + 24'd1 : w_cnt) : 24'd0;
            r_sum <= r_ok ? (w_inc ? w_sum + 40'(r_in.velocity) : w_sum) : 40'sd0;
        end
        if (i_cmd.out_load) begin
            if (r_in.opcode == OP_ADD || r_in.opcode == OP_READ) begin
                r_out.in_grid       <= r_ok;
                r_out.cell_row      <= r_orow;
                r_out.cell_col      <= r_ocol;
                r_out.hit_count     <= r_cnt;
                r_out.mean_velocity <= (r_cnt == 24'd0) ? 16'sd0 : $signed(r_mean);
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_stat.op       = r_in.opcode;
    assign o_stat.div_done = w_done;
    assign o_stat.ok       = r_ok;
    assign o_stat.cnt_zero = (r_cnt == 24'd0);
    assign o_stat.clr_last = (r_clr_addr == AW'(N - 1));
    assign o_out           = r_out;
endmodule

// File: src/pvgb_ctrl.sv
// Controller: sequences divisions, store access, clearing and result handoff.
// Depends on pvgb_pkg.
module pvgb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_opcode,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output pvgb_pkg::t_cmd  o_cmd,
    input  pvgb_pkg::t_stat i_stat
);
    import pvgb_pkg::*;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_ROWS  = 5'd2;
    localparam logic [4:0] S_WROWS = 5'd3;
    localparam logic [4:0] S_COLS  = 5'd4;
    localparam logic [4:0] S_WCOLS = 5'd5;
    localparam logic [4:0] S_X     = 5'd6;
    localparam logic [4:0] S_WX    = 5'd7;
    localparam logic [4:0] S_Y     = 5'd8;
    localparam logic [4:0] S_WY    = 5'd9;
    localparam logic [4:0] S_CHECK = 5'd10;
    localparam logic [4:0] S_ADDR  = 5'd11;
    localparam logic [4:0] S_RD    = 5'd12;
    localparam logic [4:0] S_UPD   = 5'd13;
    localparam logic [4:0] S_MEAN  = 5'd14;
    localparam logic [4:0] S_WMEAN = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_report;
    logic       n_report;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       w_cmd;

    always_comb begin
        n_state  = r_state;
        n_report = r_report;
        w_cmd    = '0;
        case (r_state)
            S_CLR: begin
                w_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = r_report ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    case (i_opcode)
                        OP_ADD, OP_READ: n_state = S_ROWS;
                        OP_CLEAR: begin
                            w_cmd.clr_rst = 1'b1;
                            n_report      = 1'b1;
                            n_state       = S_CLR;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_ROWS: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DS_ROWS;
                n_state         = S_WROWS;
            end
            S_WROWS: if (i_stat.div_done) n_state = S_COLS;
            S_COLS: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DS_COLS;
                n_state         = S_WCOLS;
            end
            S_WCOLS: begin
                if (i_stat.div_done) begin
                    n_state = (i_stat.op == OP_ADD) ? S_X : S_CHECK;
                end
            end
            S_X: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DS_X;
                n_state         = S_WX;
            end
            S_WX: if (i_stat.div_done) n_state = S_Y;
            S_Y: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DS_Y;
                n_state         = S_WY;
            end
            S_WY: if (i_stat.div_done) n_state = S_CHECK;
            S_CHECK: begin
                w_cmd.check = 1'b1;
                n_state     = S_ADDR;
            end
            S_ADDR: begin
                w_cmd.addr = 1'b1;
                n_state    = S_RD;
            end
            S_RD: begin
                w_cmd.rd = i_stat.ok;
                n_state  = S_UPD;
            end
            S_UPD: begin
                w_cmd.upd = 1'b1;
                n_state   = S_MEAN;
            end
            S_MEAN: begin
                if (i_stat.ok && !i_stat.cnt_zero) begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = DS_MEAN;
                    n_state         = S_WMEAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WMEAN: if (i_stat.div_done) n_state = S_FIN;
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_report       = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_report    <= n_report;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_div_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !i_stat.div_done)
        else $error("divider finished one cycle after start");
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_in_ready)
        else $error("input ready during clearing pass");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before taken");
endmodule
